>>> rtl/core/ascii_hex_can_line_decoder_unit_assert.svh
// assertion macros shared by the decoder rtl
`ifndef ASCII_HEX_CAN_LINE_DECODER_UNIT_ASSERT_SVH
`define ASCII_HEX_CAN_LINE_DECODER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define AHCLD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define AHCLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ahcld_pkg.sv
`default_nettype none
package ahcld_pkg;

    localparam int STORE_DEPTH    = 16;
    localparam int MIN_LINE_CHARS = 15;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [5:0]  COUNT_MAX   = 6'd63;
    localparam logic [15:0] SEED_RESET  = 16'hA5A5;
    localparam logic [31:0] ID_LOW_MASK = 32'h0001_FFFC;
    localparam int          IDE_POS     = 2;
    localparam int          RTR_POS     = 1;
    localparam logic [3:0]  MAX_DLC     = 4'd8;
    localparam logic [3:0]  CHK_BASE    = 4'd6;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_LONG  = 3'd1;
    localparam logic [2:0] ST_TOO_SHORT = 3'd2;
    localparam logic [2:0] ST_BAD_HEX   = 3'd3;
    localparam logic [2:0] ST_BAD_ID    = 3'd4;
    localparam logic [2:0] ST_BAD_DLC   = 3'd5;
    localparam logic [2:0] ST_CHECKSUM  = 3'd6;

    typedef logic [7:0] byte_t;

    // one finished line handed from the front end to the back end
    typedef struct packed {
        logic [2:0]                   status;
        logic [4:0]                   npairs;
        logic [31:0]                  sum;
        byte_t [STORE_DEPTH-1:0]      bytes;
    } line_req_t;

    // nibble in bits 3:0, bit 4 set when not a hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] nib;
        nib = 5'h10;
        if (c inside {[8'h30:8'h39]})
        begin
            nib = {1'b0, c[3:0]};
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            nib = {1'b0, 4'(c[3:0] + 4'd9)};
        end
        return nib;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/ahcld_front.sv
`default_nettype none
module ahcld_front
    import ahcld_pkg::*;
#(
    parameter int MAX_LINE_CHARS = 31
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  char_code,
    input  wire logic        line_end,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        q_full,
    output logic             q_push,
    output line_req_t        q_req
);

    localparam logic [5:0] MAX_C   = 6'(MAX_LINE_CHARS);
    localparam logic [5:0] SHORT_C = 6'(MIN_LINE_CHARS - 1);

    logic [15:0]              seed_reg, seed_next;
    logic [5:0]               count_reg, count_next;
    logic                     ovf_reg, ovf_next;
    logic [4:0]               hold_reg, hold_next;
    logic [31:0]              sum_reg, sum_next;
    logic                     bad_reg, bad_next;
    byte_t [STORE_DEPTH-1:0]  bytes_reg;

    logic       acc;
    logic [4:0] nib;
    logic [4:0] pair;
    byte_t      pair_byte;
    logic       store_we;

    assign in_ready  = !q_full;
    assign cfg_ready = 1'b1;
    assign acc       = in_valid && in_ready;
    assign nib       = hex_nibble(char_code);
    assign pair      = count_reg[5:1];
    assign pair_byte = {hold_reg[3:0], nib[3:0]};
    assign store_we  = acc && !line_end && !ovf_reg && count_reg[0] && !pair[4];
    assign q_push    = acc && line_end;

    always_comb
    begin
        q_req.npairs = pair;
        q_req.sum    = sum_reg;
        q_req.bytes  = bytes_reg;
        if (ovf_reg || count_reg >= MAX_C)
        begin
            q_req.status = ST_TOO_LONG;
        end
        else if (count_reg < SHORT_C)
        begin
            q_req.status = ST_TOO_SHORT;
        end
        else if (bad_reg)
        begin
            q_req.status = ST_BAD_HEX;
        end
        else
        begin
            q_req.status = ST_OK;
        end
    end

    always_comb
    begin
        seed_next  = seed_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        hold_next  = hold_reg;
        sum_next   = sum_reg;
        bad_next   = bad_reg;
        if (cfg_valid && cfg_ready)
        begin
            seed_next = cfg_data;
            // a seed written between lines applies at once
            if (count_reg == 6'd0 && !ovf_reg)
            begin
                sum_next = {16'h0000, cfg_data};
            end
        end
        if (acc && line_end)
        begin
            count_next = 6'd0;
            ovf_next   = 1'b0;
            hold_next  = 5'd0;
            bad_next   = 1'b0;
            sum_next   = {16'h0000, seed_next};
        end
        else if (acc)
        begin
            if (!ovf_reg)
            begin
                if (!count_reg[0])
                begin
                    hold_next = nib;
                end
                else
                begin
                    if (hold_reg[4] || nib[4])
                    begin
                        bad_next = 1'b1;
                    end
                    sum_next = sum_reg + {24'h000000, pair_byte};
                end
            end
            if (count_reg == COUNT_MAX)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= SEED_RESET;
            count_reg <= 6'd0;
            ovf_reg   <= 1'b0;
            hold_reg  <= 5'd0;
            sum_reg   <= {16'h0000, SEED_RESET};
            bad_reg   <= 1'b0;
        end
        else
        begin
            seed_reg  <= seed_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            hold_reg  <= hold_next;
            sum_reg   <= sum_next;
            bad_reg   <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            bytes_reg[pair[3:0]] <= pair_byte;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/ahcld_queue.sv
`default_nettype none
module ahcld_queue
    import ahcld_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  line_req_t       push_req,
    output logic            full,
    output logic            not_empty,
    input  wire logic       pop,
    output line_req_t       head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    line_req_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   do_push, do_pop;

    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/ahcld_back.sv
`default_nettype none
module ahcld_back
    import ahcld_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_not_empty,
    input  line_req_t   q_head,
    output logic        q_pop,
    output logic        out_valid,
    input  wire logic   out_ready,
    output logic [2:0]  status,
    output logic [7:0]  sequence_res,
    output logic [31:0] legacy_id,
    output logic [31:0] frame_id,
    output logic [3:0]  data_length,
    output logic [63:0] payload
);

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  seq;
        logic [31:0] id;
        logic [31:0] fid;
        logic [3:0]  dlc;
        logic [63:0] pay;
        logic [7:0]  chk;
        logic [31:0] x;
    } stage_t;

    logic   a_valid_reg, b_valid_reg, out_valid_reg;
    stage_t a_reg, a_next, b_reg, b_next;
    logic   a_ready, b_ready, o_ready;
    logic   a_load, b_load, o_load;

    logic [2:0]  st_reg;
    logic [7:0]  seq_reg;
    logic [31:0] id_reg, fid_reg;
    logic [3:0]  dlc_reg;
    logic [63:0] pay_reg;

    logic [31:0] id_w;
    logic [3:0]  dlc_w;
    logic [3:0]  chk_idx;
    logic        rtr_w;
    logic [31:0] x3, x4;
    logic [2:0]  fin_status;

    // ready chain through the three back stages
    assign o_ready = !out_valid_reg || out_ready;
    assign b_ready = !b_valid_reg || o_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign q_pop   = q_not_empty && a_ready;
    assign a_load  = q_pop;
    assign b_load  = a_valid_reg && b_ready;
    assign o_load  = b_valid_reg && o_ready;

    // stage a: field extraction, ordered checks, checksum byte pick
    assign id_w    = {q_head.bytes[4], q_head.bytes[3], q_head.bytes[2], q_head.bytes[1]};
    assign dlc_w   = q_head.bytes[5][3:0];
    assign chk_idx = CHK_BASE + dlc_w;
    assign rtr_w   = id_w[RTR_POS];

    always_comb
    begin
        a_next.seq = q_head.bytes[0];
        a_next.id  = id_w;
        a_next.dlc = dlc_w;
        a_next.chk = q_head.bytes[chk_idx];
        a_next.x   = q_head.sum - {24'h000000, q_head.bytes[chk_idx]};
        if (id_w[IDE_POS])
        begin
            a_next.fid = {1'b1, rtr_w, 1'b0, id_w[31:3]};
        end
        else
        begin
            a_next.fid = {1'b0, rtr_w, 19'h00000, id_w[31:21]};
        end
        for (int m = 0; m < 8; m++)
        begin
            a_next.pay[8*m +: 8] = (4'(m) < dlc_w) ? q_head.bytes[CHK_BASE + 4'(m)] : 8'h00;
        end
        if (q_head.status != ST_OK)
        begin
            a_next.status = q_head.status;
        end
        else if ((id_w & ID_LOW_MASK) != 32'h0 && !id_w[IDE_POS])
        begin
            a_next.status = ST_BAD_ID;
        end
        else if (dlc_w > MAX_DLC)
        begin
            a_next.status = ST_BAD_DLC;
        end
        else if ({1'b0, chk_idx} >= q_head.npairs)
        begin
            // checksum byte never arrived
            a_next.status = ST_CHECKSUM;
        end
        else
        begin
            a_next.status = ST_OK;
        end
    end

    // stage b: fold the upper half twice
    always_comb
    begin
        logic [31:0] x1;
        b_next   = a_reg;
        x1       = a_reg.x + {16'h0000, a_reg.x[31:16]};
        b_next.x = x1 + {16'h0000, x1[31:16]};
    end

    // last stage: fold by bytes twice and compare
    assign x3 = b_reg.x + {8'h00, b_reg.x[31:8]};
    assign x4 = x3 + {8'h00, x3[31:8]};
    assign fin_status = (b_reg.status == ST_OK && x4[7:0] != b_reg.chk) ? ST_CHECKSUM
                                                                           : b_reg.status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= q_pop;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (o_ready)
            begin
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_reg <= a_next;
        end
        if (b_load)
        begin
            b_reg <= b_next;
        end
        if (o_load)
        begin
            st_reg <= fin_status;
            if (fin_status == ST_OK)
            begin
                seq_reg <= b_reg.seq;
                id_reg  <= b_reg.id;
                fid_reg <= b_reg.fid;
                dlc_reg <= b_reg.dlc;
                pay_reg <= b_reg.pay;
            end
            else
            begin
                seq_reg <= 8'h00;
                id_reg  <= 32'h0;
                fid_reg <= 32'h0;
                dlc_reg <= 4'h0;
                pay_reg <= 64'h0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = st_reg;
    assign sequence_res = seq_reg;
    assign legacy_id    = id_reg;
    assign frame_id     = fid_reg;
    assign data_length  = dlc_reg;
    assign payload      = pay_reg;

endmodule
`default_nettype wire

>>> rtl/core/ascii_hex_can_line_decoder_unit.sv
// ASCII-hex CAN line decoder. Takes one character per clock on the input channel;
// the character flagged line_end closes the line and produces exactly one result,
// which passes the two-entry line queue and then three back-end stages (checks,
// 16-bit fold, 8-bit fold and compare) and is shown when the output is free. The front
// end keeps taking characters while earlier lines are still being judged; in_ready
// drops only when the line queue is full because results are not being taken. The
// checksum seed is written through the cfg channel between lines, and a new seed
// applies from the next line on. No clearing pass is needed after reset.
`default_nettype none
module ascii_hex_can_line_decoder_unit
    import ahcld_pkg::*;
#(
    parameter int MAX_LINE_CHARS = 31
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  char_code,
    input  wire logic        line_end,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [7:0]       sequence_res,
    output logic [31:0]      legacy_id,
    output logic [31:0]      frame_id,
    output logic [3:0]       data_length,
    output logic [63:0]      payload,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

`include "ascii_hex_can_line_decoder_unit_assert.svh"

    logic      q_full, q_push, q_not_empty, q_pop;
    line_req_t q_req, q_head;

    ahcld_front #(
        .MAX_LINE_CHARS (MAX_LINE_CHARS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .line_end  (line_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_req     (q_req)
    );

    ahcld_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_req  (q_req),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .head      (q_head)
    );

    ahcld_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .sequence_res (sequence_res),
        .legacy_id    (legacy_id),
        .frame_id     (frame_id),
        .data_length  (data_length),
        .payload      (payload)
    );

    `AHCLD_ASSERT_IMPLY(a_ok_dlc, clk, rst_n, out_valid && status == ST_OK,
        data_length <= MAX_DLC, "good line with dlc above eight")
    `AHCLD_ASSERT_IMPLY(a_err_zero, clk, rst_n, out_valid && status != ST_OK,
        legacy_id == 32'h0 && frame_id == 32'h0 && payload == 64'h0 &&
        sequence_res == 8'h00 && data_length == 4'h0, "failed line carries data")
    `AHCLD_ASSERT_IMPLY(a_status_range, clk, rst_n, out_valid,
        status <= ST_CHECKSUM, "status code out of range")
    `AHCLD_ASSERT_NEXT(a_line_queued, clk, rst_n, q_push,
        q_not_empty, "line end request lost before the queue")

endmodule
`default_nettype wire
